// ===== sv/ubx_nav_frame_parser_assert.svh =====
// Assertion macros for the UBX frame parser.
`ifndef UBX_NAV_FRAME_PARSER_ASSERT_SVH
`define UBX_NAV_FRAME_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define UNFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("UBX parser assertion failed");
`define UNFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("UBX parser assertion failed");
`else
`define UNFP_ASSERT_IMP(lbl, ante, cons)
`define UNFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== sv/ubxnav_pkg.sv =====
package ubxnav_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] NAV_CLASS   = 8'h01;

  localparam int FLAG_DOP = 0;
  localparam int FLAG_POS = 1;
  localparam int FLAG_SOL = 2;
  localparam int FLAG_VEL = 3;

  localparam int OFS_LON     = 4;
  localparam int OFS_LAT     = 8;
  localparam int OFS_HDOP    = 12;
  localparam int OFS_SPEED   = 20;
  localparam int OFS_HEADING = 24;
  localparam int OFS_SATS    = 47;

  localparam logic [15:0] MIN_LEN_POS = 16'd12;
  localparam logic [15:0] MIN_LEN_DOP = 16'd14;
  localparam logic [15:0] MIN_LEN_SOL = 16'd48;
  localparam logic [15:0] MIN_LEN_VEL = 16'd28;

  typedef enum logic [1:0] {
    CFG_POSLLH = 2'd0,
    CFG_DOP    = 2'd1,
    CFG_SOL    = 2'd2,
    CFG_VELNED = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_BAD_CHECKSUM = 3'd0,
    ST_POSITION     = 3'd1,
    ST_DOP          = 3'd2,
    ST_SOLUTION     = 3'd3,
    ST_VELOCITY     = 3'd4,
    ST_OTHER        = 3'd5,
    ST_TOO_SHORT    = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] posllh_id;
    logic [7:0] dop_id;
    logic [7:0] sol_id;
    logic [7:0] velned_id;
  } msg_ids_t;

  typedef struct packed {
    logic        done;
    logic        chk_ok;
    logic [7:0]  cls;
    logic [7:0]  id;
    logic [15:0] len;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [15:0] hdop;
    logic [7:0]  sats;
    logic [31:0] speed;
    logic [31:0] heading;
  } frame_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [15:0] hdop;
    logic [7:0]  sats;
    logic [31:0] speed;
    logic [31:0] heading;
    logic [3:0]  flags;
    logic        any;
  } result_t;

endpackage

// ===== sv/ubxnav_framer.sv =====
module ubxnav_framer
  import ubxnav_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  localparam int          IDX_W     = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [15:0] DEPTH_LEN = 16'(PAYLOAD_DEPTH);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHK_A   = 4'd7,
    PH_CHK_B   = 4'd8
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         sum_a_r, sum_a_nxt;
  logic [7:0]         sum_b_r, sum_b_nxt;
  logic [7:0]         cls_r, cls_nxt;
  logic [7:0]         id_r, id_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [7:0]         chk_a_r, chk_a_nxt;
  logic [31:0]        lon_r, lon_nxt;
  logic [31:0]        lat_r, lat_nxt;
  logic [15:0]        hdop_r, hdop_nxt;
  logic [7:0]         sats_r, sats_nxt;
  logic [31:0]        speed_r, speed_nxt;
  logic [31:0]        heading_r, heading_nxt;
  logic [7:0]         add_a;
  logic [7:0]         add_b;
  logic [15:0]        len_full;

  always_comb begin
    phase_nxt   = phase_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    cls_nxt     = cls_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    chk_a_nxt   = chk_a_r;
    lon_nxt     = lon_r;
    lat_nxt     = lat_r;
    hdop_nxt    = hdop_r;
    sats_nxt    = sats_r;
    speed_nxt   = speed_r;
    heading_nxt = heading_r;
    add_a       = sum_a_r + rx_byte;
    add_b       = sum_b_r + add_a;
    len_full    = {rx_byte, len_r[7:0]};

    frame.done    = 1'b0;
    frame.chk_ok  = (sum_a_r == chk_a_r) && (sum_b_r == rx_byte);
    frame.cls     = cls_r;
    frame.id      = id_r;
    frame.len     = len_r;
    frame.lon     = lon_r;
    frame.lat     = lat_r;
    frame.hdop    = hdop_r;
    frame.sats    = sats_r;
    frame.speed   = speed_r;
    frame.heading = heading_r;

    if (byte_en) begin
      case (phase_r)
        PH_SYNC1: begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          if (rx_byte == SYNC_FIRST) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_nxt = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
        end
        PH_CLASS: begin
          cls_nxt   = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = rx_byte;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {8'h00, rx_byte};
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = len_full;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          idx_nxt   = '0;
          if (len_full > DEPTH_LEN) begin
            phase_nxt = PH_SYNC1;
          end else if (len_full == 16'd0) begin
            phase_nxt = PH_CHK_A;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          idx_nxt   = idx_r + 1'b1;
          if (idx_r >= IDX_W'(OFS_LON) && idx_r < IDX_W'(OFS_LON + 4)) begin
            lon_nxt[{idx_r[1:0], 3'b000} +: 8] = rx_byte;
          end
          if (idx_r >= IDX_W'(OFS_LAT) && idx_r < IDX_W'(OFS_LAT + 4)) begin
            lat_nxt[{idx_r[1:0], 3'b000} +: 8] = rx_byte;
          end
          if (idx_r >= IDX_W'(OFS_HDOP) && idx_r < IDX_W'(OFS_HDOP + 2)) begin
            hdop_nxt[{idx_r[0], 3'b000} +: 8] = rx_byte;
          end
          if (idx_r >= IDX_W'(OFS_SPEED) && idx_r < IDX_W'(OFS_SPEED + 4)) begin
            speed_nxt[{idx_r[1:0], 3'b000} +: 8] = rx_byte;
          end
          if (idx_r >= IDX_W'(OFS_HEADING) && idx_r < IDX_W'(OFS_HEADING + 4)) begin
            heading_nxt[{idx_r[1:0], 3'b000} +: 8] = rx_byte;
          end
          if (idx_r == IDX_W'(OFS_SATS)) begin
            sats_nxt = rx_byte;
          end
          if (16'(idx_nxt) >= len_r) begin
            phase_nxt = PH_CHK_A;
          end
        end
        PH_CHK_A: begin
          chk_a_nxt = rx_byte;
          phase_nxt = PH_CHK_B;
        end
        PH_CHK_B: begin
          frame.done = 1'b1;
          phase_nxt  = PH_SYNC1;
        end
        default: begin
          phase_nxt = PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      sum_a_r <= '0;
      sum_b_r <= '0;
      cls_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      chk_a_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      cls_r   <= cls_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      chk_a_r <= chk_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lon_r     <= lon_nxt;
    lat_r     <= lat_nxt;
    hdop_r    <= hdop_nxt;
    sats_r    <= sats_nxt;
    speed_r   <= speed_nxt;
    heading_r <= heading_nxt;
  end

endmodule

// ===== sv/ubxnav_latch.sv =====
module ubxnav_latch
  import ubxnav_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     clr_en,
  input  frame_t   frame,
  input  msg_ids_t ids,
  input  logic     out_take,
  output logic     out_valid,
  output result_t  result
);

  logic        out_valid_r, out_valid_nxt;
  result_t     result_r, result_nxt;
  logic [31:0] lon_r, lon_nxt;
  logic [31:0] lat_r, lat_nxt;
  logic [15:0] hdop_r, hdop_nxt;
  logic [7:0]  sats_r, sats_nxt;
  logic [31:0] speed_r, speed_nxt;
  logic [31:0] heading_r, heading_nxt;
  logic [3:0]  avail_r, avail_nxt;
  status_t     status;

  always_comb begin
    lon_nxt     = lon_r;
    lat_nxt     = lat_r;
    hdop_nxt    = hdop_r;
    sats_nxt    = sats_r;
    speed_nxt   = speed_r;
    heading_nxt = heading_r;
    avail_nxt   = avail_r;
    status      = ST_BAD_CHECKSUM;

    if (clr_en) begin
      avail_nxt = '0;
    end

    if (frame.done && frame.chk_ok) begin
      if (frame.cls != NAV_CLASS) begin
        status = ST_OTHER;
      end else if (frame.id == ids.posllh_id) begin
        if (frame.len < MIN_LEN_POS) begin
          status = ST_TOO_SHORT;
        end else begin
          status              = ST_POSITION;
          lon_nxt             = frame.lon;
          lat_nxt             = frame.lat;
          avail_nxt[FLAG_POS] = 1'b1;
        end
      end else if (frame.id == ids.dop_id) begin
        if (frame.len < MIN_LEN_DOP) begin
          status = ST_TOO_SHORT;
        end else begin
          status              = ST_DOP;
          hdop_nxt            = frame.hdop;
          avail_nxt[FLAG_DOP] = 1'b1;
        end
      end else if (frame.id == ids.sol_id) begin
        if (frame.len < MIN_LEN_SOL) begin
          status = ST_TOO_SHORT;
        end else begin
          status              = ST_SOLUTION;
          sats_nxt            = frame.sats;
          avail_nxt[FLAG_SOL] = 1'b1;
        end
      end else if (frame.id == ids.velned_id) begin
        if (frame.len < MIN_LEN_VEL) begin
          status = ST_TOO_SHORT;
        end else begin
          status              = ST_VELOCITY;
          speed_nxt           = frame.speed;
          heading_nxt         = frame.heading;
          avail_nxt[FLAG_VEL] = 1'b1;
        end
      end else begin
        status = ST_OTHER;
      end
    end

    out_valid_nxt = frame.done | (out_valid_r & ~out_take);
    result_nxt    = result_r;
    if (frame.done) begin
      result_nxt.status  = status;
      result_nxt.lon     = lon_nxt;
      result_nxt.lat     = lat_nxt;
      result_nxt.hdop    = hdop_nxt;
      result_nxt.sats    = sats_nxt;
      result_nxt.speed   = speed_nxt;
      result_nxt.heading = heading_nxt;
      result_nxt.flags   = avail_nxt;
      result_nxt.any     = |avail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      lon_r       <= '0;
      lat_r       <= '0;
      hdop_r      <= '0;
      sats_r      <= '0;
      speed_r     <= '0;
      heading_r   <= '0;
      avail_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      lon_r       <= lon_nxt;
      lat_r       <= lat_nxt;
      hdop_r      <= hdop_nxt;
      sats_r      <= sats_nxt;
      speed_r     <= speed_nxt;
      heading_r   <= heading_nxt;
      avail_r     <= avail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== sv/ubx_nav_frame_parser.sv =====
// UBX navigation frame parser. One request is taken per clock: either a received
// byte or a request to clear the available flags. Every byte moves the frame state
// by one step, so a request can be accepted in every cycle; the only thing that
// holds the input back is a status result that is still waiting at the output.
// The status for a frame appears in the cycle after its second checksum byte is
// accepted and carries a snapshot of all held navigation values and flags.
// Frames longer than PAYLOAD_DEPTH are dropped without a status. Message ids
// may be reconfigured only while the parser is idle.
module ubx_nav_frame_parser
  import ubxnav_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_frame_status,
  output logic signed [31:0] out_longitude,
  output logic signed [31:0] out_latitude,
  output logic [15:0]        out_hdop,
  output logic [7:0]         out_sats_used,
  output logic [31:0]        out_ground_speed,
  output logic signed [31:0] out_heading,
  output logic [3:0]         out_available_flags,
  output logic               out_any_available,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

`include "ubx_nav_frame_parser_assert.svh"

  msg_ids_t ids_r, ids_nxt;
  frame_t   frame;
  result_t  result;
  logic     in_take;
  logic     out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;

  always_comb begin
    ids_nxt = ids_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_POSLLH: ids_nxt.posllh_id = cfg_data;
        CFG_DOP:    ids_nxt.dop_id    = cfg_data;
        CFG_SOL:    ids_nxt.sol_id    = cfg_data;
        CFG_VELNED: ids_nxt.velned_id = cfg_data;
        default:    ids_nxt           = ids_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ids_r.posllh_id <= 8'd2;
      ids_r.dop_id    <= 8'd4;
      ids_r.sol_id    <= 8'd6;
      ids_r.velned_id <= 8'd18;
    end else begin
      ids_r <= ids_nxt;
    end
  end

  ubxnav_framer #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_framer (
    .clk    (clk),
    .rst_n  (rst_n),
    .byte_en(in_take & ~in_req_type),
    .rx_byte(in_rx_byte),
    .frame  (frame)
  );

  ubxnav_latch u_latch (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_en   (in_take & in_req_type),
    .frame    (frame),
    .ids      (ids_r),
    .out_take (out_take),
    .out_valid(out_valid),
    .result   (result)
  );

  assign out_frame_status    = result.status;
  assign out_longitude       = $signed(result.lon);
  assign out_latitude        = $signed(result.lat);
  assign out_hdop            = result.hdop;
  assign out_sats_used       = result.sats;
  assign out_ground_speed    = result.speed;
  assign out_heading         = $signed(result.heading);
  assign out_available_flags = result.flags;
  assign out_any_available   = result.any;

  `UNFP_ASSERT_IMP(a_stall_only_when_full, in_stall, out_valid)
  `UNFP_ASSERT_IMP(a_pos_sets_flag, out_valid && out_frame_status == ST_POSITION,
                   out_available_flags[FLAG_POS])
  `UNFP_ASSERT_IMP(a_vel_sets_flag, out_valid && out_frame_status == ST_VELOCITY,
                   out_available_flags[FLAG_VEL])
  `UNFP_ASSERT_NXT(a_clear_gives_no_result, in_take && in_req_type && !out_valid,
                   !out_valid)

endmodule

// ===== tb/tb_ubx_nav_frame_parser.sv =====
`timescale 1ns / 100ps

module tb_ubx_nav_frame_parser;
  import ubxnav_pkg::*;

  localparam int DEPTH = 64;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } parse_phase_t;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_kind_t;

  typedef logic [7:0] octet_q_t[$];

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_req_type;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_frame_status;
  logic signed [31:0] out_longitude;
  logic signed [31:0] out_latitude;
  logic [15:0]        out_hdop;
  logic [7:0]         out_sats_used;
  logic [31:0]        out_ground_speed;
  logic signed [31:0] out_heading;
  logic [3:0]         out_available_flags;
  logic               out_any_available;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;

  ubx_nav_frame_parser #(
    .PAYLOAD_DEPTH(DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_status   (out_frame_status),
    .out_longitude      (out_longitude),
    .out_latitude       (out_latitude),
    .out_hdop           (out_hdop),
    .out_sats_used      (out_sats_used),
    .out_ground_speed   (out_ground_speed),
    .out_heading        (out_heading),
    .out_available_flags(out_available_flags),
    .out_any_available  (out_any_available),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  parse_phase_t ph;
  logic [7:0]   run_a;
  logic [7:0]   run_b;
  logic [7:0]   f_cls;
  logic [7:0]   f_id;
  logic [15:0]  f_len;
  logic [15:0]  f_idx;
  logic [7:0]   ck_a_rx;
  logic [7:0]   store [DEPTH];
  msg_ids_t     ids;
  logic [31:0]  held_lon;
  logic [31:0]  held_lat;
  logic [15:0]  held_hdop;
  logic [7:0]   held_sats;
  logic [31:0]  held_speed;
  logic [31:0]  held_heading;
  logic [3:0]   flags;

  result_t expected_reports[$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  reports_checked = 0;
  int  settings_used = 0;
  int  receiver_hold = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] stored(int i);
    return (i < DEPTH) ? store[i] : 8'h00;
  endfunction

  function automatic logic [31:0] stored32(int i);
    return {stored(i + 3), stored(i + 2), stored(i + 1), stored(i)};
  endfunction

  function automatic void add_sum(logic [7:0] b);
    run_a = run_a + b;
    run_b = run_b + run_a;
  endfunction

  function automatic void reset_predictor();
    ph = PH_SYNC1;
    run_a = '0;
    run_b = '0;
    f_cls = '0;
    f_id = '0;
    f_len = '0;
    f_idx = '0;
    ck_a_rx = '0;
    ids = '{posllh_id: 8'd2, dop_id: 8'd4, sol_id: 8'd6, velned_id: 8'd18};
    held_lon = '0;
    held_lat = '0;
    held_hdop = '0;
    held_sats = '0;
    held_speed = '0;
    held_heading = '0;
    flags = '0;
  endfunction

  function automatic status_t close_frame();
    if (run_a != ck_a_rx) return ST_BAD_CHECKSUM;
    if (f_cls != NAV_CLASS) return ST_OTHER;
    if (f_id == ids.posllh_id) begin
      if (f_len < MIN_LEN_POS) return ST_TOO_SHORT;
      held_lon = stored32(OFS_LON);
      held_lat = stored32(OFS_LAT);
      flags[FLAG_POS] = 1'b1;
      return ST_POSITION;
    end
    if (f_id == ids.dop_id) begin
      if (f_len < MIN_LEN_DOP) return ST_TOO_SHORT;
      held_hdop = {stored(OFS_HDOP + 1), stored(OFS_HDOP)};
      flags[FLAG_DOP] = 1'b1;
      return ST_DOP;
    end
    if (f_id == ids.sol_id) begin
      if (f_len < MIN_LEN_SOL) return ST_TOO_SHORT;
      held_sats = stored(OFS_SATS);
      flags[FLAG_SOL] = 1'b1;
      return ST_SOLUTION;
    end
    if (f_id == ids.velned_id) begin
      if (f_len < MIN_LEN_VEL) return ST_TOO_SHORT;
      held_speed = stored32(OFS_SPEED);
      held_heading = stored32(OFS_HEADING);
      flags[FLAG_VEL] = 1'b1;
      return ST_VELOCITY;
    end
    return ST_OTHER;
  endfunction

  function automatic void advance_parser(req_kind_t kind, logic [7:0] b);
    result_t r;
    if (kind == REQ_CLEAR) begin
      flags = '0;
      return;
    end
    case (ph)
      PH_SYNC1: begin
        run_a = '0;
        run_b = '0;
        if (b == SYNC_FIRST) ph = PH_SYNC2;
      end
      PH_SYNC2: ph = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      PH_CLASS: begin
        f_cls = b;
        add_sum(b);
        ph = PH_ID;
      end
      PH_ID: begin
        f_id = b;
        add_sum(b);
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        f_len = {8'h00, b};
        add_sum(b);
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        f_len[15:8] = b;
        add_sum(b);
        f_idx = '0;
        if (f_len > DEPTH) ph = PH_SYNC1;
        else if (f_len == 0) ph = PH_CK_A;
        else ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (f_idx < DEPTH) store[f_idx] = b;
        f_idx = f_idx + 16'd1;
        add_sum(b);
        if (f_idx >= f_len) ph = PH_CK_A;
      end
      PH_CK_A: begin
        ck_a_rx = b;
        ph = PH_CK_B;
      end
      PH_CK_B: begin
        r.status = (run_b == b) ? close_frame() : ST_BAD_CHECKSUM;
        r.lon = held_lon;
        r.lat = held_lat;
        r.hdop = held_hdop;
        r.sats = held_sats;
        r.speed = held_speed;
        r.heading = held_heading;
        r.flags = flags;
        r.any = |flags;
        expected_reports.push_back(r);
        ph = PH_SYNC1;
      end
      default: ph = PH_SYNC1;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("frame report with status %0d arrived with none expected", out_frame_status);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("frame_status", want.status, out_frame_status);
        compare_field("longitude", want.lon, out_longitude);
        compare_field("latitude", want.lat, out_latitude);
        compare_field("hdop", want.hdop, out_hdop);
        compare_field("sats_used", want.sats, out_sats_used);
        compare_field("ground_speed", want.speed, out_ground_speed);
        compare_field("heading", want.heading, out_heading);
        compare_field("available_flags", want.flags, out_available_flags);
        compare_field("any_available", want.any, out_any_available);
        reports_checked++;
      end
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_hold > 0) begin
        out_stall <= 1'b1;
        repeat (receiver_hold) @(posedge clk);
        receiver_hold = 0;
        out_stall <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(req_kind_t kind, logic [7:0] b);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    advance_parser(kind, b);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_ids(msg_ids_t v);
    settle_idle();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(k);
      case (cfg_index_t'(k))
        CFG_POSLLH: cfg_data <= v.posllh_id;
        CFG_DOP:    cfg_data <= v.dop_id;
        CFG_SOL:    cfg_data <= v.sol_id;
        default:    cfg_data <= v.velned_id;
      endcase
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    ids = v;
    settings_used++;
  endtask

  function automatic octet_q_t random_body(int n);
    octet_q_t q;
    for (int k = 0; k < n; k++) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic put_le(ref octet_q_t q, input int ofs, input logic [31:0] v, input int nb);
    for (int k = 0; k < nb; k++) q[ofs + k] = v[8*k +: 8];
  endtask

  task automatic send_frame(logic [7:0] cls, logic [7:0] id, octet_q_t body,
                            logic [1:0] spoil, int clear_at);
    octet_q_t   octets;
    logic [15:0] n;
    logic [7:0]  a;
    logic [7:0]  b;
    n = 16'(body.size());
    octets.push_back(SYNC_FIRST);
    octets.push_back(SYNC_SECOND);
    octets.push_back(cls);
    octets.push_back(id);
    octets.push_back(n[7:0]);
    octets.push_back(n[15:8]);
    foreach (body[k]) octets.push_back(body[k]);
    a = '0;
    b = '0;
    for (int k = 2; k < octets.size(); k++) begin
      a = a + octets[k];
      b = b + a;
    end
    if (spoil[0]) a = a ^ 8'($urandom_range(1, 255));
    if (spoil[1]) b = b ^ 8'($urandom_range(1, 255));
    octets.push_back(a);
    octets.push_back(b);
    foreach (octets[k]) begin
      if (k == clear_at) send_request(REQ_CLEAR, 8'($urandom));
      send_request(REQ_BYTE, octets[k]);
    end
  endtask

  task automatic resync_parser();
    while (ph != PH_SYNC1) send_request(REQ_BYTE, 8'h00);
  endtask

  task automatic test_nav_kinds();
    octet_q_t body;
    body = random_body(MIN_LEN_POS);
    put_le(body, OFS_LON, 32'h7FFF_FFFF, 4);
    put_le(body, OFS_LAT, 32'h8000_0000, 4);
    send_frame(NAV_CLASS, ids.posllh_id, body, 2'b00, -1);
    body = random_body(MIN_LEN_DOP);
    put_le(body, OFS_HDOP, 32'hFFFF, 2);
    send_frame(NAV_CLASS, ids.dop_id, body, 2'b00, -1);
    body = random_body(DEPTH);
    body[OFS_SATS] = 8'hFF;
    send_frame(NAV_CLASS, ids.sol_id, body, 2'b00, -1);
    body = random_body(MIN_LEN_VEL);
    put_le(body, OFS_SPEED, 32'hFFFF_FFFF, 4);
    put_le(body, OFS_HEADING, 32'h8000_0000, 4);
    send_frame(NAV_CLASS, ids.velned_id, body, 2'b00, -1);
  endtask

  task automatic test_frame_faults();
    octet_q_t none;
    send_frame(8'h05, 8'h01, none, 2'b00, -1);
    send_frame(NAV_CLASS, 8'h30, none, 2'b00, -1);
    send_frame(NAV_CLASS, ids.posllh_id, none, 2'b00, -1);
    send_frame(NAV_CLASS, ids.posllh_id, none, 2'b01, -1);
    send_frame(NAV_CLASS, ids.dop_id, none, 2'b10, -1);
    send_frame(NAV_CLASS, ids.velned_id, none, 2'b11, -1);
    send_frame(NAV_CLASS, ids.posllh_id, random_body(MIN_LEN_POS - 1), 2'b00, -1);
    send_frame(NAV_CLASS, ids.sol_id, random_body(5), 2'b00, -1);
  endtask

  task automatic send_oversize_header(logic [15:0] len);
    send_request(REQ_BYTE, SYNC_FIRST);
    send_request(REQ_BYTE, SYNC_SECOND);
    send_request(REQ_BYTE, NAV_CLASS);
    send_request(REQ_BYTE, ids.posllh_id);
    send_request(REQ_BYTE, len[7:0]);
    send_request(REQ_BYTE, len[15:8]);
  endtask

  task automatic test_sync_and_oversize();
    octet_q_t none;
    send_request(REQ_BYTE, SYNC_FIRST);
    send_request(REQ_BYTE, SYNC_FIRST);
    send_frame(8'h05, 8'h01, none, 2'b00, -1);
    send_oversize_header(16'(DEPTH + 1));
    send_frame(NAV_CLASS, 8'h30, none, 2'b00, -1);
    send_oversize_header(16'hFFFF);
    send_request(REQ_BYTE, 8'h11);
  endtask

  task automatic test_clear_requests();
    octet_q_t none;
    send_request(REQ_CLEAR, 8'hFF);
    send_frame(NAV_CLASS, ids.posllh_id, random_body(MIN_LEN_POS), 2'b00, 9);
    send_request(REQ_CLEAR, 8'h00);
    send_frame(NAV_CLASS, 8'h77, none, 2'b00, -1);
  endtask

  task automatic test_msg_id_registers();
    msg_ids_t v;
    octet_q_t none;
    v = '{posllh_id: 8'h00, dop_id: 8'hFF, sol_id: 8'h80, velned_id: 8'h7F};
    program_ids(v);
    send_frame(NAV_CLASS, 8'h00, random_body(MIN_LEN_POS), 2'b00, -1);
    send_frame(NAV_CLASS, 8'hFF, none, 2'b00, -1);
    v = '{posllh_id: 8'h55, dop_id: 8'h55, sol_id: 8'h55, velned_id: 8'h55};
    program_ids(v);
    send_frame(NAV_CLASS, 8'h55, random_body(MIN_LEN_POS), 2'b00, -1);
    v = '{posllh_id: 8'h09, dop_id: 8'h55, sol_id: 8'h55, velned_id: 8'h20};
    program_ids(v);
    send_frame(NAV_CLASS, 8'h55, random_body(MIN_LEN_DOP), 2'b00, -1);
    v = '{posllh_id: 8'd2, dop_id: 8'd4, sol_id: 8'd6, velned_id: 8'd18};
    program_ids(v);
  endtask

  task automatic test_backpressure();
    octet_q_t none;
    settle_idle();
    sender_idles = 1'b0;
    receiver_hold = 300;
    repeat (4) send_frame(8'h0A, 8'h04, none, 2'b00, -1);
    sender_idles = 1'b1;
    settle_idle();
  endtask

  task automatic send_noise();
    int          n;
    logic [15:0] big;
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 6);
        repeat (n) send_request(REQ_BYTE, ($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
      end
      1: begin
        send_request(REQ_BYTE, SYNC_FIRST);
        send_request(REQ_BYTE, 8'($urandom));
      end
      2: begin
        big = 16'($urandom_range(DEPTH + 1, 65535));
        send_oversize_header(big);
      end
      default: send_request(REQ_CLEAR, 8'($urandom));
    endcase
    resync_parser();
  endtask

  task automatic send_random_frame();
    logic [7:0] cls;
    logic [7:0] id;
    int         n;
    int         min_len;
    int         r;
    logic [1:0] spoil;
    int         clear_at;
    cls = NAV_CLASS;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        id = ids.posllh_id;
        min_len = MIN_LEN_POS;
      end
      3, 4: begin
        id = ids.dop_id;
        min_len = MIN_LEN_DOP;
      end
      5: begin
        id = ids.sol_id;
        min_len = MIN_LEN_SOL;
      end
      6, 7: begin
        id = ids.velned_id;
        min_len = MIN_LEN_VEL;
      end
      8: begin
        id = 8'($urandom);
        min_len = 0;
      end
      default: begin
        cls = 8'($urandom);
        id = 8'($urandom);
        min_len = 0;
      end
    endcase
    r = $urandom_range(0, 9);
    if (r == 0) n = $urandom_range(0, (min_len > 0) ? min_len - 1 : 0);
    else if (r == 1) n = $urandom_range(0, DEPTH);
    else n = min_len + $urandom_range(0, 6);
    if (n > DEPTH) n = DEPTH;
    spoil = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    clear_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n + 7) : -1;
    send_frame(cls, id, random_body(n), spoil, clear_at);
  endtask

  task automatic test_random_traffic();
    msg_ids_t v;
    v = ids;
    v.posllh_id = 8'($urandom);
    v.dop_id = ($urandom_range(0, 1) == 0) ? v.posllh_id : 8'($urandom);
    v.sol_id = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
    v.velned_id = 8'($urandom);
    program_ids(v);
    while (requests_sent < 460) begin
      if (requests_sent > 400) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_random_frame();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_BYTE;
    in_rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_POSLLH;
    cfg_data <= 8'h00;
    reset_predictor();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_nav_kinds();
    test_frame_faults();
    test_sync_and_oversize();
    test_clear_requests();
    test_msg_id_registers();
    test_backpressure();
    test_random_traffic();
    settle_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests, %0d frame reports and %0d message id settings.",
             requests_sent, reports_checked, settings_used);
    $display("Traffic held sync loss, oversize drops, short and empty frames, clears and stalls.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== ubx_nav_frame_parser.f =====
+incdir+sv
sv/ubxnav_pkg.sv
sv/ubxnav_framer.sv
sv/ubxnav_latch.sv
sv/ubx_nav_frame_parser.sv
tb/tb_ubx_nav_frame_parser.sv
